// ===== design/attg_pkg.sv =====
// ----------------------------------------------------------------------------
// attg_pkg
// Shared types and codes for the text terminal grid: command word passed
// from parser to executor, result word, character and register codes.
// ----------------------------------------------------------------------------
package attg_pkg;

  // command word opcodes
  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_CSI  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // CSI commands
  localparam logic [7:0] CMD_A = 8'h41;
  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_C = 8'h43;
  localparam logic [7:0] CMD_D = 8'h44;
  localparam logic [7:0] CMD_H = 8'h48;
  localparam logic [7:0] CMD_J = 8'h4A;
  localparam logic [7:0] CMD_K = 8'h4B;
  localparam logic [7:0] CMD_F = 8'h66;

  localparam logic [15:0] PARAM_MAX = 16'hFFFF;
  localparam logic [3:0]  IDX_STOP  = 4'd8;
  localparam logic [3:0]  IDX_CAPT  = 4'd15;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;     // byte, or CSI command byte
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  rrow;
    logic [6:0]  rcol;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] line;
    logic [7:0] pos;
    logic [7:0] view;
  } res_t;

endpackage

// ===== design/attg_ram.sv =====
// ----------------------------------------------------------------------------
// attg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module attg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/attg_fifo.sv =====
// ----------------------------------------------------------------------------
// attg_fifo
// Small register queue; holds command words and result words.
// ----------------------------------------------------------------------------
module attg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== design/attg_front.sv =====
// ----------------------------------------------------------------------------
// attg_front
// Escape parser. Takes one word a cycle unless stalled, tracks ESC/CSI/OSC/charset
// state, gathers CSI parameters and emits one command word per input word.
// ----------------------------------------------------------------------------
module attg_front #(
  parameter int SEQ_BUFFER = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                stall,
  input  logic                func,
  input  logic [7:0]          ob,
  input  logic [7:0]          rrow,
  input  logic [6:0]          rcol,
  output logic                full,
  output logic                cq_push,
  output attg_pkg::cmd_t      cmd
);

  localparam int SLW = $clog2(SEQ_BUFFER);

  localparam logic [2:0] PS_NORM   = 3'd0;
  localparam logic [2:0] PS_ESC    = 3'd1;
  localparam logic [2:0] PS_CSI    = 3'd2;
  localparam logic [2:0] PS_OSC    = 3'd3;
  localparam logic [2:0] PS_CHS    = 3'd4;
  localparam logic [2:0] PS_OSCESC = 3'd5;

  logic [2:0]     ps_r, ps_nxt;
  logic [SLW-1:0] seq_r, seq_nxt;
  logic [15:0]    p1_r, p1_nxt, p2_r, p2_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [7:0]     fc_r, fc_nxt;
  logic           acc, is_digit, is_final;
  logic [19:0]    p1_mul, p2_mul, digit;

  assign full     = stall;
  assign acc      = push & ~stall;
  assign cq_push  = acc;
  assign is_digit = (ob >= attg_pkg::CH_0) && (ob <= attg_pkg::CH_9);
  assign is_final = (ob >= attg_pkg::CH_AT) && (ob <= attg_pkg::CH_TILDE) &&
                    (ob != attg_pkg::CH_LBR);
  assign digit    = 20'(ob - attg_pkg::CH_0);
  // x*10 as (x<<3)+(x<<1)
  assign p1_mul   = (20'(p1_r) << 3) + (20'(p1_r) << 1) + digit;
  assign p2_mul   = (20'(p2_r) << 3) + (20'(p2_r) << 1) + digit;

  always_comb begin
    ps_nxt   = ps_r;
    seq_nxt  = seq_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    idx_nxt  = idx_r;
    fc_nxt   = fc_r;
    cmd.op   = attg_pkg::OP_NOP;
    cmd.ch   = ob;
    cmd.p1   = '0;
    cmd.p2   = '0;
    cmd.rrow = rrow;
    cmd.rcol = rcol;
    if (func) begin
      cmd.op = attg_pkg::OP_READ;
    end else begin
      case (ps_r)
        PS_ESC: begin
          case (ob)
            attg_pkg::CH_LBR:  ps_nxt = PS_CSI;
            attg_pkg::CH_RBR:  ps_nxt = PS_OSC;
            attg_pkg::CH_LPAR: ps_nxt = PS_CHS;
            default:           ps_nxt = PS_NORM;
          endcase
        end
        PS_CSI: begin
          if (seq_r < SLW'(SEQ_BUFFER - 1)) begin
            seq_nxt = seq_r + SLW'(1);
            if (idx_r == attg_pkg::IDX_STOP) begin
              fc_nxt  = ob;
              idx_nxt = attg_pkg::IDX_CAPT;
            end else if (idx_r < attg_pkg::IDX_STOP) begin
              if (is_digit) begin
                if (idx_r == 4'd0) begin
                  p1_nxt = (p1_mul > 20'(attg_pkg::PARAM_MAX)) ? attg_pkg::PARAM_MAX
                                                               : p1_mul[15:0];
                end else if (idx_r == 4'd1) begin
                  p2_nxt = (p2_mul > 20'(attg_pkg::PARAM_MAX)) ? attg_pkg::PARAM_MAX
                                                               : p2_mul[15:0];
                end
              end else if (ob == attg_pkg::CH_SEMI) begin
                idx_nxt = idx_r + 4'd1;
              end else begin
                fc_nxt  = ob;
                idx_nxt = attg_pkg::IDX_CAPT;
              end
            end
          end
          if (is_final) begin
            ps_nxt = PS_NORM;
            if (idx_nxt == attg_pkg::IDX_CAPT) begin
              cmd.op = attg_pkg::OP_CSI;
              cmd.ch = fc_nxt;
              cmd.p1 = p1_nxt;
              cmd.p2 = p2_nxt;
            end
          end
        end
        PS_OSC: begin
          if (ob == attg_pkg::CH_BEL) begin
            ps_nxt = PS_NORM;
          end else if (ob == attg_pkg::CH_ESC) begin
            ps_nxt = PS_OSCESC;
          end
        end
        PS_CHS: ps_nxt = PS_NORM;
        PS_OSCESC: ps_nxt = (ob == attg_pkg::CH_BSL) ? PS_NORM : PS_OSC;
        default: begin
          if (ob == attg_pkg::CH_ESC) begin
            ps_nxt  = PS_ESC;
            seq_nxt = '0;
            p1_nxt  = '0;
            p2_nxt  = '0;
            idx_nxt = '0;
            fc_nxt  = '0;
          end else begin
            ps_nxt = PS_NORM;
            cmd.op = attg_pkg::OP_CHAR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r  <= PS_NORM;
      seq_r <= '0;
      p1_r  <= '0;
      p2_r  <= '0;
      idx_r <= '0;
      fc_r  <= '0;
    end else if (acc) begin
      ps_r  <= ps_nxt;
      seq_r <= seq_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      idx_r <= idx_nxt;
      fc_r  <= fc_nxt;
    end
  end

endmodule

// ===== design/attg_back.sv =====
// ----------------------------------------------------------------------------
// attg_back
// Executor. Owns cursor, view and ring base, and the character grid RAM.
// Runs one command word at a time, sweeps erased spans one cell a cycle,
// and posts one result word per command.
// ----------------------------------------------------------------------------
module attg_back #(
  parameter int SCROLLBACK_ROWS = 256,
  parameter int MAX_COLUMNS     = 128,
  parameter int TAB_STOP        = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         cfg_cols,
  input  logic [6:0]         cfg_rows,
  output logic               busy,
  input  logic               cq_empty,
  input  attg_pkg::cmd_t     cmd,
  output logic               cq_pop,
  input  logic               rq_full,
  output logic               rq_push,
  output attg_pkg::res_t     res
);

  localparam int RW    = $clog2(SCROLLBACK_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH = SCROLLBACK_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RECIP = 65536 / TAB_STOP;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] init_r, init_nxt;
  logic [RW-1:0] ring_r, ring_nxt, row_r, row_nxt, vt_r, vt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          rdsel_r, rdsel_nxt, pend_r, pend_nxt;
  logic [7:0]    pch_r, pch_nxt;
  logic [RW-1:0] crow_r, crow_nxt;
  logic [CW-1:0] ccol_r, ccol_nxt, cto_r, cto_nxt, tq_r, tq_nxt;
  logic [RW:0]   cend_r, cend_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic [CW-1:0] cols_e;
  logic [RW:0]   rows_e;
  logic          sc_wrap;
  logic [RW-1:0] sc_row, sc_ring, sc_vt;
  logic [15:0]   p_csi;
  logic [16:0]   px, rowx, colx, vtx, colsx, rmaxx, tsx;
  logic [16:0]   b_sum, c_sum, h_sum, h_col, j_sum, t_est, t_rem, t_next;
  logic [RW:0]   j_end;
  logic [CW-1:0] k_to;
  logic [CW+16:0] t_prod;
  logic          rd_ok;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] ring,
                                              input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    logic [RW:0] ph;
    ph = {1'b0, ring} + {1'b0, row};
    if (ph >= (RW+1)'(SCROLLBACK_ROWS)) ph = ph - (RW+1)'(SCROLLBACK_ROWS);
    cell_addr = AW'(AW'(ph[RW-1:0]) * AW'(MAX_COLUMNS)) + AW'(col);
  endfunction

  function automatic logic [RW-1:0] view_of(input logic [RW:0] rn1, input logic [RW:0] rows);
    view_of = (rn1 >= rows) ? RW'(rn1 - rows) : '0;
  endfunction

  // effective register values
  assign cols_e = (cfg_cols < 8'd10) ? CW'(10) :
                  ((9'(cfg_cols) > 9'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cfg_cols));
  assign rows_e = (cfg_rows < 7'd3) ? (RW+1)'(3) :
                  ((16'(cfg_rows) > 16'(SCROLLBACK_ROWS)) ? (RW+1)'(SCROLLBACK_ROWS)
                                                          : (RW+1)'(cfg_rows));

  // line feed / wrap scroll
  assign sc_wrap = (row_r == RW'(SCROLLBACK_ROWS - 1));
  assign sc_row  = sc_wrap ? row_r : row_r + RW'(1);
  assign sc_ring = (ring_r == RW'(SCROLLBACK_ROWS - 1)) ? '0 : ring_r + RW'(1);
  assign sc_vt   = view_of({1'b0, sc_row} + (RW+1)'(1), rows_e);

  assign p_csi  = (cmd.p1 == 16'd0) ? 16'd1 : cmd.p1;
  assign px     = 17'(p_csi);
  assign rowx   = 17'(row_r);
  assign colx   = 17'(col_r);
  assign vtx    = 17'(vt_r);
  assign colsx  = 17'(cols_e);
  assign rmaxx  = 17'(SCROLLBACK_ROWS - 1);
  assign tsx    = 17'(TAB_STOP);
  assign b_sum  = rowx + px;
  assign c_sum  = colx + px;
  assign h_sum  = vtx + px - 17'd1;
  assign h_col  = (cmd.p2 == 16'd0) ? 17'd0 : 17'(cmd.p2) - 17'd1;
  assign j_sum  = vtx + 17'(rows_e);
  assign j_end  = (j_sum > 17'(SCROLLBACK_ROWS)) ? (RW+1)'(SCROLLBACK_ROWS) : (RW+1)'(j_sum);
  assign k_to   = (colx + 17'd1 > 17'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(colx + 17'd1);

  // tab: quotient estimate by reciprocal, one correction step
  assign t_prod = (CW+17)'(col_r) * (CW+17)'(RECIP);
  assign t_est  = colx - 17'(17'(tq_r) * tsx);
  assign t_rem  = (t_est >= tsx) ? t_est - tsx : t_est;
  assign t_next = colx - t_rem + tsx;

  assign rd_ok = (16'(cmd.rrow) < 16'(SCROLLBACK_ROWS)) && (9'(cmd.rcol) < 9'(MAX_COLUMNS));
  assign busy  = (st_r == S_INIT);

  always_comb begin
    st_nxt    = st_r;
    init_nxt  = init_r;
    ring_nxt  = ring_r;
    row_nxt   = row_r;
    vt_nxt    = vt_r;
    col_nxt   = col_r;
    rdsel_nxt = rdsel_r;
    pend_nxt  = pend_r;
    pch_nxt   = pch_r;
    crow_nxt  = crow_r;
    ccol_nxt  = ccol_r;
    cto_nxt   = cto_r;
    cend_nxt  = cend_r;
    tq_nxt    = tq_r;
    we        = 1'b0;
    waddr     = cell_addr(ring_r, row_r, col_r);
    wdata     = attg_pkg::CH_SPACE;
    re        = 1'b0;
    raddr     = cell_addr(ring_r, RW'(cmd.rrow), CW'(cmd.rcol));
    cq_pop    = 1'b0;
    rq_push   = 1'b0;
    res.cell_char = rdsel_r ? rdata : 8'd0;
    res.line  = 8'(row_r);
    res.pos   = 8'(col_r);
    res.view  = 8'(vt_r);
    case (st_r)
      S_INIT: begin
        we       = 1'b1;
        waddr    = init_r;
        init_nxt = init_r + AW'(1);
        if (init_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!cq_empty && !rq_full) begin
          cq_pop    = 1'b1;
          st_nxt    = S_RESP;
          rdsel_nxt = 1'b0;
          pend_nxt  = 1'b0;
          case (cmd.op)
            attg_pkg::OP_READ: begin
              if (rd_ok) begin
                re        = 1'b1;
                rdsel_nxt = 1'b1;
              end
            end
            attg_pkg::OP_CHAR: begin
              case (cmd.ch)
                attg_pkg::CH_LF: begin
                  row_nxt  = sc_row;
                  vt_nxt   = sc_vt;
                  col_nxt  = '0;
                  if (sc_wrap) begin
                    ring_nxt = sc_ring;
                    crow_nxt = RW'(SCROLLBACK_ROWS - 1);
                    ccol_nxt = '0;
                    cto_nxt  = CW'(MAX_COLUMNS);
                    cend_nxt = (RW+1)'(SCROLLBACK_ROWS);
                    st_nxt   = S_CLEAR;
                  end
                end
                attg_pkg::CH_CR: col_nxt = '0;
                attg_pkg::CH_TAB: begin
                  tq_nxt = CW'(t_prod >> 16);
                  st_nxt = S_TAB;
                end
                attg_pkg::CH_BS, attg_pkg::CH_DEL: begin
                  if (col_r != '0) col_nxt = col_r - CW'(1);
                end
                attg_pkg::CH_BEL: ;
                default: begin
                  if (col_r >= cols_e) begin
                    // pending wrap: scroll first, then write at column 0
                    row_nxt = sc_row;
                    vt_nxt  = sc_vt;
                    if (sc_wrap) begin
                      ring_nxt = sc_ring;
                      col_nxt  = '0;
                      pend_nxt = 1'b1;
                      pch_nxt  = cmd.ch;
                      crow_nxt = RW'(SCROLLBACK_ROWS - 1);
                      ccol_nxt = '0;
                      cto_nxt  = CW'(MAX_COLUMNS);
                      cend_nxt = (RW+1)'(SCROLLBACK_ROWS);
                      st_nxt   = S_CLEAR;
                    end else begin
                      we      = 1'b1;
                      waddr   = cell_addr(ring_r, sc_row, '0);
                      wdata   = cmd.ch;
                      col_nxt = CW'(1);
                    end
                  end else begin
                    we      = 1'b1;
                    wdata   = cmd.ch;
                    col_nxt = col_r + CW'(1);
                  end
                end
              endcase
            end
            attg_pkg::OP_CSI: begin
              case (cmd.ch)
                attg_pkg::CMD_A: row_nxt = (rowx > px) ? RW'(rowx - px) : '0;
                attg_pkg::CMD_B: row_nxt = (b_sum >= 17'(SCROLLBACK_ROWS)) ? RW'(rmaxx)
                                                                           : RW'(b_sum);
                attg_pkg::CMD_C: col_nxt = (c_sum >= colsx) ? CW'(colsx - 17'd1) : CW'(c_sum);
                attg_pkg::CMD_D: col_nxt = (colx > px) ? CW'(colx - px) : '0;
                attg_pkg::CMD_H, attg_pkg::CMD_F: begin
                  row_nxt = (h_sum >= 17'(SCROLLBACK_ROWS)) ? RW'(rmaxx) : RW'(h_sum);
                  col_nxt = (h_col >= colsx) ? CW'(colsx - 17'd1) : CW'(h_col);
                end
                attg_pkg::CMD_J: begin
                  if (cmd.p1 == 16'd2 || cmd.p1 == 16'd3) begin
                    row_nxt  = vt_r;
                    col_nxt  = '0;
                    crow_nxt = vt_r;
                    ccol_nxt = '0;
                    cto_nxt  = cols_e;
                    cend_nxt = j_end;
                    st_nxt   = S_CLEAR;
                  end else if (cmd.p1 == 16'd0) begin
                    crow_nxt = row_r;
                    ccol_nxt = col_r;
                    cto_nxt  = cols_e;
                    cend_nxt = j_end;
                    st_nxt   = S_CLEAR;
                  end
                end
                attg_pkg::CMD_K: begin
                  crow_nxt = row_r;
                  cend_nxt = {1'b0, row_r} + (RW+1)'(1);
                  if (cmd.p1 == 16'd0) begin
                    ccol_nxt = col_r;
                    cto_nxt  = cols_e;
                    st_nxt   = S_CLEAR;
                  end else if (cmd.p1 == 16'd1) begin
                    ccol_nxt = '0;
                    cto_nxt  = k_to;
                    st_nxt   = S_CLEAR;
                  end else if (cmd.p1 == 16'd2) begin
                    ccol_nxt = '0;
                    cto_nxt  = cols_e;
                    st_nxt   = S_CLEAR;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_TAB: begin
        col_nxt = (t_next > colsx) ? cols_e : CW'(t_next);
        st_nxt  = S_RESP;
      end
      S_CLEAR: begin
        if (ccol_r < cto_r) begin
          we       = 1'b1;
          waddr    = cell_addr(ring_r, crow_r, ccol_r);
          ccol_nxt = ccol_r + CW'(1);
        end else if ({1'b0, crow_r} + (RW+1)'(1) < cend_r) begin
          crow_nxt = crow_r + RW'(1);
          ccol_nxt = '0;
          cto_nxt  = cols_e;
        end else begin
          if (pend_r) begin
            we       = 1'b1;
            waddr    = cell_addr(ring_r, row_r, '0);
            wdata    = pch_r;
            col_nxt  = CW'(1);
            pend_nxt = 1'b0;
          end
          st_nxt = S_RESP;
        end
      end
      S_RESP: begin
        rq_push = 1'b1;
        st_nxt  = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_INIT;
      init_r  <= '0;
      ring_r  <= '0;
      row_r   <= '0;
      vt_r    <= '0;
      col_r   <= '0;
      rdsel_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      init_r  <= init_nxt;
      ring_r  <= ring_nxt;
      row_r   <= row_nxt;
      vt_r    <= vt_nxt;
      col_r   <= col_nxt;
      rdsel_r <= rdsel_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pch_r  <= pch_nxt;
    crow_r <= crow_nxt;
    ccol_r <= ccol_nxt;
    cto_r  <= cto_nxt;
    cend_r <= cend_nxt;
    tq_r   <= tq_nxt;
  end

  attg_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // commands are never popped back to back
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |=> !cq_pop) else $error("back-to-back command pops");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MAX_COLUMNS)) else $error("cursor column past grid");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < (RW+1)'(SCROLLBACK_ROWS)) else $error("cursor row past scrollback");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (st_r == S_CLEAR)) else $error("pending write outside row clear");

endmodule

// ===== design/ansi_text_terminal_grid.sv =====
// ----------------------------------------------------------------------------
// ansi_text_terminal_grid
// VT100-style terminal: escape parser feeding a scrollback character grid.
// ----------------------------------------------------------------------------
// After reset the grid is swept to spaces, one cell a cycle, over all
// SCROLLBACK_ROWS*MAX_COLUMNS cells (32768 by default); in_full stays high
// until then. The parser takes one word a cycle into a four-deep command
// queue while that queue is not full; the executor pops each command, runs
// it and posts its result word from a separate response state. A tab passes
// through a tab state first, and erases and a scroll at the last scrollback
// row first sweep their cells to spaces, row by row.
module ansi_text_terminal_grid #(
  parameter int SCROLLBACK_ROWS = 256,
  parameter int MAX_COLUMNS     = 128,
  parameter int TAB_STOP        = 8,
  parameter int SEQ_BUFFER      = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_out_byte,
  input  logic [7:0] in_read_row,
  input  logic [6:0] in_read_column,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cursor_line,
  output logic [7:0] out_cursor_position,
  output logic [7:0] out_view_first_row
);

  logic [7:0]       cols_r;
  logic [6:0]       rows_r;
  logic             busy, cq_push, cq_full, cq_empty, cq_pop, rq_push, rq_full;
  attg_pkg::cmd_t   cmd_in, cmd_out;
  attg_pkg::res_t   res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 8'd80;
      rows_r <= 7'd24;
    end else if (cfg_we) begin
      if (cfg_index == attg_pkg::REG_COLUMNS) cols_r <= cfg_wdata;
      if (cfg_index == attg_pkg::REG_ROWS)    rows_r <= cfg_wdata[6:0];
    end
  end

  attg_front #(
    .SEQ_BUFFER(SEQ_BUFFER)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .stall  (cq_full | busy),
    .func   (in_func),
    .ob     (in_out_byte),
    .rrow   (in_read_row),
    .rcol   (in_read_column),
    .full   (in_full),
    .cq_push(cq_push),
    .cmd    (cmd_in)
  );

  attg_fifo #(
    .WIDTH($bits(attg_pkg::cmd_t)),
    .DEPTH(4)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .wdata(cmd_in),
    .full (cq_full),
    .pop  (cq_pop),
    .rdata(cmd_out),
    .empty(cq_empty)
  );

  attg_back #(
    .SCROLLBACK_ROWS(SCROLLBACK_ROWS),
    .MAX_COLUMNS    (MAX_COLUMNS),
    .TAB_STOP       (TAB_STOP)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_cols(cols_r),
    .cfg_rows(rows_r),
    .busy    (busy),
    .cq_empty(cq_empty),
    .cmd     (cmd_out),
    .cq_pop  (cq_pop),
    .rq_full (rq_full),
    .rq_push (rq_push),
    .res     (res_in)
  );

  attg_fifo #(
    .WIDTH($bits(attg_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .wdata(res_in),
    .full (rq_full),
    .pop  (out_pop),
    .rdata(res_out),
    .empty(out_empty)
  );

  assign out_cell_char       = res_out.cell_char;
  assign out_cursor_line     = res_out.line;
  assign out_cursor_position = res_out.pos;
  assign out_view_first_row  = res_out.view;

endmodule

// ===== sim/tb_ansi_text_terminal_grid.sv =====
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal_grid
// Self-checking bench for the escape-parsing text terminal grid. A directed
// table exercises control bytes, several CSI commands, OSC/charset skipping,
// parameter saturation and extreme reads; random escape-heavy traffic
// follows under several column/row settings and handshake idle patterns. Every
// result word is compared against a behavioural grid/parser model or a fixed word.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal_grid;

  localparam int SB_ROWS    = 256;
  localparam int MAX_COLS   = 128;
  localparam int TAB_W      = 8;
  localparam int SEQ_BUF    = 32;
  localparam int STALL_MAX  = 200000;

  typedef enum int unsigned {
    PS_TEXT, PS_ESC, PS_CSI, PS_OSC, PS_CHARSET, PS_OSC_ESC
  } parse_e;

  typedef struct {
    logic             func;
    logic [7:0]       b;
    logic [7:0]       rr;
    logic [6:0]       rc;
    bit               typed;
    attg_pkg::res_t   want;
  } stim_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_push;
  logic       in_full;
  logic       in_func;
  logic [7:0] in_out_byte;
  logic [7:0] in_read_row;
  logic [6:0] in_read_column;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_cell_char;
  logic [7:0] out_cursor_line;
  logic [7:0] out_cursor_position;
  logic [7:0] out_view_first_row;

  ansi_text_terminal_grid dut (.*);

  // terminal model state
  logic [7:0]  scr [0:SB_ROWS*MAX_COLS-1];
  int unsigned base_row, crow, ccol, vtop;
  parse_e      pstate;
  int unsigned slen, p1, p2, pidx, fchar;
  int unsigned cols_reg, rows_reg;

  stim_t            stim_q[$];
  attg_pkg::res_t   pending_q[$];
  bit               cur_typed;
  attg_pkg::res_t   cur_want;
  int               send_idle, recv_stall;
  int               words_in, words_out, errors, idle_cycles, settings_seen;

  function automatic int unsigned cols_eff();
    int unsigned c;
    c = cols_reg;
    if (c < 10) c = 10;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned rows_eff();
    int unsigned r;
    r = rows_reg;
    if (r < 3) r = 3;
    if (r > SB_ROWS) r = SB_ROWS;
    return r;
  endfunction

  function automatic int unsigned cell_at(int unsigned r, int unsigned c);
    return ((base_row + r) % SB_ROWS) * MAX_COLS + c;
  endfunction

  function automatic void blank_span(int unsigned r, int unsigned from, int unsigned upto);
    int unsigned c;
    if (r >= SB_ROWS) return;
    if (upto > MAX_COLS) upto = MAX_COLS;
    for (c = from; c < upto; c++) scr[cell_at(r, c)] = attg_pkg::CH_SPACE;
  endfunction

  function automatic void line_feed();
    int unsigned rows;
    rows = rows_eff();
    crow++;
    if (crow >= SB_ROWS) begin
      base_row = (base_row + 1) % SB_ROWS;
      crow = SB_ROWS - 1;
      blank_span(crow, 0, MAX_COLS);
    end
    vtop = (crow + 1 >= rows) ? crow + 1 - rows : 0;
  endfunction

  function automatic void write_char(logic [7:0] ch);
    int unsigned cols, nxt;
    cols = cols_eff();
    if (ch == attg_pkg::CH_LF) begin
      line_feed();
      ccol = 0;
    end else if (ch == attg_pkg::CH_CR) begin
      ccol = 0;
    end else if (ch == attg_pkg::CH_TAB) begin
      nxt = (ccol / TAB_W + 1) * TAB_W;
      ccol = (nxt > cols) ? cols : nxt;
    end else if (ch == attg_pkg::CH_BS || ch == attg_pkg::CH_DEL) begin
      if (ccol > 0) ccol--;
    end else if (ch != attg_pkg::CH_BEL) begin
      if (ccol >= cols) begin
        line_feed();
        ccol = 0;
      end
      scr[cell_at(crow, ccol)] = ch;
      ccol++;
    end
  endfunction

  function automatic void exec_csi();
    int unsigned cols, n, last, r;
    cols = cols_eff();
    n = (p1 != 0) ? p1 : 1;
    if (pidx != attg_pkg::IDX_CAPT) return;
    case (fchar[7:0])
      attg_pkg::CMD_A: crow = (crow > n) ? crow - n : 0;
      attg_pkg::CMD_B: begin
        crow += n;
        if (crow >= SB_ROWS) crow = SB_ROWS - 1;
      end
      attg_pkg::CMD_C: begin
        ccol += n;
        if (ccol >= cols) ccol = cols - 1;
      end
      attg_pkg::CMD_D: ccol = (ccol > n) ? ccol - n : 0;
      attg_pkg::CMD_H, attg_pkg::CMD_F: begin
        crow = vtop + n - 1;
        if (crow >= SB_ROWS) crow = SB_ROWS - 1;
        ccol = (p2 != 0) ? p2 - 1 : 0;
        if (ccol >= cols) ccol = cols - 1;
      end
      attg_pkg::CMD_J: begin
        last = vtop + rows_eff();
        if (last > SB_ROWS) last = SB_ROWS;
        if (p1 == 2 || p1 == 3) begin
          for (r = vtop; r < last; r++) blank_span(r, 0, cols);
          crow = vtop;
          ccol = 0;
        end else if (p1 == 0) begin
          blank_span(crow, ccol, cols);
          for (r = crow + 1; r < last; r++) blank_span(r, 0, cols);
        end
      end
      attg_pkg::CMD_K: begin
        if (p1 == 0) blank_span(crow, ccol, cols);
        else if (p1 == 1) blank_span(crow, 0, ccol + 1);
        else if (p1 == 2) blank_span(crow, 0, cols);
      end
      default: ;
    endcase
  endfunction

  function automatic void csi_take(logic [7:0] ch);
    int unsigned v;
    if (slen < SEQ_BUF - 1) begin
      slen++;
      if (pidx == attg_pkg::IDX_STOP) begin
        fchar = 32'(ch);
        pidx = attg_pkg::IDX_CAPT;
      end else if (pidx < attg_pkg::IDX_STOP) begin
        if (ch >= attg_pkg::CH_0 && ch <= attg_pkg::CH_9) begin
          if (pidx == 0) begin
            v = p1 * 10 + 32'(ch - attg_pkg::CH_0);
            p1 = (v > attg_pkg::PARAM_MAX) ? 32'(attg_pkg::PARAM_MAX) : v;
          end else if (pidx == 1) begin
            v = p2 * 10 + 32'(ch - attg_pkg::CH_0);
            p2 = (v > attg_pkg::PARAM_MAX) ? 32'(attg_pkg::PARAM_MAX) : v;
          end
        end else if (ch == attg_pkg::CH_SEMI) begin
          pidx++;
        end else begin
          fchar = 32'(ch);
          pidx = attg_pkg::IDX_CAPT;
        end
      end
    end
    if (ch >= attg_pkg::CH_AT && ch <= attg_pkg::CH_TILDE && ch != attg_pkg::CH_LBR) begin
      exec_csi();
      pstate = PS_TEXT;
    end
  endfunction

  function automatic void feed_byte(logic [7:0] ch);
    case (pstate)
      PS_ESC: begin
        if (ch == attg_pkg::CH_LBR) pstate = PS_CSI;
        else if (ch == attg_pkg::CH_RBR) pstate = PS_OSC;
        else if (ch == attg_pkg::CH_LPAR) pstate = PS_CHARSET;
        else pstate = PS_TEXT;
      end
      PS_CSI: csi_take(ch);
      PS_OSC: begin
        if (ch == attg_pkg::CH_BEL) pstate = PS_TEXT;
        else if (ch == attg_pkg::CH_ESC) pstate = PS_OSC_ESC;
      end
      PS_CHARSET: pstate = PS_TEXT;
      PS_OSC_ESC: pstate = (ch == attg_pkg::CH_BSL) ? PS_TEXT : PS_OSC;
      default: begin
        if (ch == attg_pkg::CH_ESC) begin
          pstate = PS_ESC;
          slen = 0;
          p1 = 0;
          p2 = 0;
          pidx = 0;
          fchar = 0;
        end else begin
          write_char(ch);
        end
      end
    endcase
  endfunction

  function automatic attg_pkg::res_t terminal_step(logic func, logic [7:0] b,
                                                   logic [7:0] rr, logic [6:0] rc);
    attg_pkg::res_t r;
    r.cell_char = 8'h00;
    if (func == 1'b0) feed_byte(b);
    else r.cell_char = scr[cell_at(rr, rc)];
    r.line = crow[7:0];
    r.pos  = ccol[7:0];
    r.view = vtop[7:0];
    return r;
  endfunction

  // --- stimulus builders ---------------------------------------------------
  function automatic stim_t byte_word(logic [7:0] b);
    stim_t s;
    s.func = 1'b0;
    s.b = b;
    s.rr = 8'($urandom_range(0, 255));
    s.rc = 7'($urandom_range(0, 127));
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_t read_word(logic [7:0] rr, logic [6:0] rc);
    stim_t s;
    s.func = 1'b1;
    s.b = 8'($urandom_range(0, 255));
    s.rr = rr;
    s.rc = rc;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic void queue_text(string t);
    int i;
    for (i = 0; i < t.len(); i++) stim_q.push_back(byte_word(t[i]));
  endfunction

  function automatic void queue_digits(int unsigned n);
    queue_text($sformatf("%0d", n));
  endfunction

  // one random shell-output fragment; returns number of words queued
  function automatic int queue_fragment();
    int q_start, k, n, i, np;
    logic [7:0] cmd;
    q_start = stim_q.size();
    k = $urandom_range(0, 99);
    if (k < 32) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) cmd = 8'($urandom_range(0, 255));
        else cmd = 8'($urandom_range(attg_pkg::CH_SPACE, attg_pkg::CH_TILDE));
        if (cmd == attg_pkg::CH_ESC) cmd = attg_pkg::CH_SPACE;
        stim_q.push_back(byte_word(cmd));
      end
    end else if (k < 46) begin
      case ($urandom_range(0, 6))
        0: cmd = attg_pkg::CH_LF;
        1: cmd = attg_pkg::CH_CR;
        2: cmd = attg_pkg::CH_TAB;
        3: cmd = attg_pkg::CH_BS;
        4: cmd = attg_pkg::CH_DEL;
        5: cmd = attg_pkg::CH_BEL;
        default: cmd = 8'($urandom_range(0, 26));
      endcase
      stim_q.push_back(byte_word(cmd));
    end else if (k < 72) begin
      stim_q.push_back(byte_word(attg_pkg::CH_ESC));
      stim_q.push_back(byte_word(attg_pkg::CH_LBR));
      if ($urandom_range(0, 19) == 0) begin
        // overlong sequence: command may fall past the stored part
        n = $urandom_range(30, 40);
        for (i = 0; i < n; i++)
          stim_q.push_back(byte_word(8'($urandom_range(attg_pkg::CH_0, attg_pkg::CH_9))));
      end else begin
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 1);
        for (i = 0; i <= np; i++) begin
          if (i > 0) stim_q.push_back(byte_word(attg_pkg::CH_SEMI));
          case ($urandom_range(0, 5))
            0: ;
            1: queue_digits($urandom_range(0, 3));
            2: queue_digits($urandom_range(0, 300));
            3: queue_digits($urandom_range(0, 9999999));
            default: queue_digits($urandom_range(0, 40));
          endcase
        end
      end
      case ($urandom_range(0, 31))
        0, 1, 2, 3: cmd = attg_pkg::CMD_A;
        4, 5, 6, 7: cmd = attg_pkg::CMD_B;
        8, 9, 10, 11: cmd = attg_pkg::CMD_C;
        12, 13, 14, 15: cmd = attg_pkg::CMD_D;
        16, 17, 18: cmd = attg_pkg::CMD_H;
        19, 20, 21: cmd = attg_pkg::CMD_F;
        22, 23, 24, 25: cmd = attg_pkg::CMD_K;
        26: cmd = attg_pkg::CMD_J;
        27: cmd = attg_pkg::CH_LBR;
        default: cmd = 8'($urandom_range(attg_pkg::CH_AT, attg_pkg::CH_TILDE));
      endcase
      if (cmd == attg_pkg::CMD_J && $urandom_range(0, 2) != 0) cmd = attg_pkg::CMD_K;
      stim_q.push_back(byte_word(cmd));
      if (cmd == attg_pkg::CH_LBR) stim_q.push_back(byte_word(attg_pkg::CMD_C));
    end else if (k < 77) begin
      stim_q.push_back(byte_word(attg_pkg::CH_ESC));
      stim_q.push_back(byte_word(attg_pkg::CH_RBR));
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        cmd = 8'($urandom_range(0, 255));
        if (cmd == attg_pkg::CH_BEL) cmd = attg_pkg::CH_SPACE;
        stim_q.push_back(byte_word(cmd));
      end
      if ($urandom_range(0, 1) != 0) begin
        stim_q.push_back(byte_word(attg_pkg::CH_BEL));
      end else begin
        stim_q.push_back(byte_word(attg_pkg::CH_ESC));
        stim_q.push_back(byte_word(attg_pkg::CH_BSL));
      end
    end else if (k < 80) begin
      stim_q.push_back(byte_word(attg_pkg::CH_ESC));
      stim_q.push_back(byte_word(attg_pkg::CH_LPAR));
      stim_q.push_back(byte_word(8'($urandom_range(0, 255))));
    end else if (k < 83) begin
      stim_q.push_back(byte_word(attg_pkg::CH_ESC));
      stim_q.push_back(byte_word(8'($urandom_range(0, 255))));
    end else if (k < 97) begin
      if ($urandom_range(0, 1) != 0)
        stim_q.push_back(read_word(8'($urandom_range(0, 255)),
                                   7'($urandom_range(0, 127))));
      else
        stim_q.push_back(read_word(8'(crow[7:0] - 8'($urandom_range(0, 3))),
                                   7'($urandom_range(0, 20))));
    end else begin
      // jump to the bottom of the scrollback and scroll the ring
      queue_text("\033[300B");
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        queue_text("xy");
        stim_q.push_back(byte_word(attg_pkg::CH_LF));
      end
    end
    return stim_q.size() - q_start;
  endfunction

  // --- clock, drivers --------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_word(stim_t s);
    int seen;
    while ($urandom_range(0, 99) < send_idle) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_func = s.func;
    in_out_byte = s.b;
    in_read_row = s.rr;
    in_read_column = s.rc;
    cur_typed = s.typed;
    cur_want = s.want;
    seen = words_in;
    do @(negedge clk); while (words_in == seen);
    in_push = 1'b0;
  endtask

  task automatic drain_queue();
    while (stim_q.size() > 0) send_word(stim_q.pop_front());
    while (pending_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == attg_pkg::REG_COLUMNS) cols_reg = val;
    else rows_reg = val & 8'h7F;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // --- acceptance, checking, watchdog ---------------------------------------
  always @(posedge clk) begin
    attg_pkg::res_t exp_r, got;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        exp_r = terminal_step(in_func, in_out_byte, in_read_row, in_read_column);
        pending_q.push_back(cur_typed ? cur_want : exp_r);
        words_in <= words_in + 1;
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        words_out <= words_out + 1;
        got = '{out_cell_char, out_cursor_line, out_cursor_position, out_view_first_row};
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_r = pending_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("word %0d: exp char %h line %0d pos %0d view %0d, got %h %0d %0d %0d",
                       words_out, exp_r.cell_char, exp_r.line, exp_r.pos, exp_r.view,
                       got.cell_char, got.line, got.pos, got.view);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles > STALL_MAX) begin
        $display("ansi_text_terminal_grid verification failed");
        $finish;
      end
    end
  end

  // --- main sequence -----------------------------------------------------
  initial begin
    stim_t s;
    int ph, made;
    int col_set[6];
    int row_set[6];
    col_set = '{80, 10, 128, 255, 0, 37};
    row_set = '{24, 3, 64, 127, 0, 9};
    for (int i = 0; i < SB_ROWS * MAX_COLS; i++) scr[i] = attg_pkg::CH_SPACE;
    base_row = 0; crow = 0; ccol = 0; vtop = 0; pstate = PS_TEXT;
    slen = 0; p1 = 0; p2 = 0; pidx = 0; fchar = 0;
    cols_reg = 80; rows_reg = 24;
    words_in = 0; words_out = 0; errors = 0; idle_cycles = 0; settings_seen = 0;
    send_idle = 0; recv_stall = 0;
    cur_typed = 1'b0; cur_want = '0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = attg_pkg::REG_COLUMNS; cfg_wdata = '0;
    in_push = 1'b0; in_func = 1'b0; in_out_byte = '0; in_read_row = '0;
    in_read_column = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    s = read_word(8'd0, 7'd0);
    s.typed = 1'b1; s.want = '{attg_pkg::CH_SPACE, 8'd0, 8'd0, 8'd0};
    stim_q.push_back(s);
    s = byte_word("A");
    s.typed = 1'b1; s.want = '{8'h00, 8'd0, 8'd1, 8'd0};
    stim_q.push_back(s);
    s = read_word(8'd0, 7'd0);
    s.typed = 1'b1; s.want = '{"A", 8'd0, 8'd1, 8'd0};
    stim_q.push_back(s);
    stim_q.push_back(byte_word(8'hFF));
    stim_q.push_back(byte_word(8'h01));
    stim_q.push_back(byte_word(attg_pkg::CH_TAB));
    stim_q.push_back(byte_word(attg_pkg::CH_BS));
    stim_q.push_back(byte_word(attg_pkg::CH_DEL));
    stim_q.push_back(byte_word(attg_pkg::CH_BEL));
    stim_q.push_back(byte_word(attg_pkg::CH_LF));
    stim_q.push_back(byte_word(attg_pkg::CH_CR));
    queue_text("\033[99999999C");        // saturating count, clamps to last col
    queue_text("\033[2;3H\033[1K");
    queue_text("\033]t\007\033(B\033x");
    stim_q.push_back(read_word(8'd255, 7'd127));
    drain_queue();
    queue_text("\033[2J\033[;;;;;;;;fA");  // eight separators: next byte is the command
    drain_queue();

    for (ph = 0; ph < 6; ph++) begin
      write_reg(attg_pkg::REG_COLUMNS, 8'(col_set[ph]));
      write_reg(attg_pkg::REG_ROWS, 8'(row_set[ph]));
      settings_seen++;
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      made = 0;
      while (made < 225) made += queue_fragment();
      drain_queue();
    end

    repeat (100) @(negedge clk);
    $display("%0d words sent, %0d results checked across %0d register settings",
             words_in, words_out, settings_seen);
    $display("escapes, erases, scrollback wrap and cell reads under four idle patterns");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ansi_text_terminal_grid verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_q.size());
      $display("ansi_text_terminal_grid verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/attg_pkg.sv
design/attg_ram.sv
design/attg_fifo.sv
design/attg_front.sv
design/attg_back.sv
design/ansi_text_terminal_grid.sv
sim/tb_ansi_text_terminal_grid.sv
